FILE: sv/tcs_pkg.sv
// shared constants, types and helpers of the tridiagonal cholesky sampler
// no dependencies; imported by tcs_divsqrt and the sampler top
package tcs_pkg;

  localparam int MAX_LEN   = 64;
  localparam int FRAC_BITS = 20;
  localparam int DW        = 32;
  localparam int AW        = $clog2(MAX_LEN);
  localparam int CW        = AW + 1;
  // shift register of the divide / root unit, even so roots take two bits a step
  localparam int ACC_W     = 2 * ((DW + FRAC_BITS + 1) / 2);
  localparam int CNT_W     = $clog2(ACC_W + 1);
  localparam int REM_W     = DW + 1;
  localparam int PROD_W    = 2 * DW;
  localparam int MQ_W      = PROD_W - FRAC_BITS;
  localparam int SUM_W     = MQ_W + 2;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } tcs_op_e;

  typedef struct packed {
    logic    start;
    tcs_op_e op;
  } tcs_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LDIV,
    S_LWAIT,
    S_MULA,
    S_TRNA,
    S_ARG,
    S_SQWAIT,
    S_MULB,
    S_TRNB,
    S_NUM,
    S_WWAIT,
    S_BINIT,
    S_BRD,
    S_BMUL,
    S_BTRN,
    S_BSUB,
    S_BWAIT,
    S_ORD,
    S_OWAIT,
    S_OHOLD
  } tcs_state_e;

  // clamp a wide signed sum to the signed word range
  function automatic logic signed [DW-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = $signed({{(SUM_W-DW+1){1'b0}}, {(DW-1){1'b1}}});
    lo = $signed({{(SUM_W-DW+1){1'b1}}, {(DW-1){1'b0}}});
    if (v > hi) begin
      sat32 = hi[DW-1:0];
    end else if (v < lo) begin
      sat32 = lo[DW-1:0];
    end else begin
      sat32 = v[DW-1:0];
    end
  endfunction

  // product scaled down by the fraction bits, truncated toward zero
  function automatic logic signed [MQ_W-1:0] trunc_q(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] bias;
    logic [PROD_W-1:0] s;
    bias = {{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{p[PROD_W-1]}}};
    s    = p + bias;
    trunc_q = $signed(s[PROD_W-1:FRAC_BITS]);
  endfunction

endpackage

FILE: sv/tcs_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module tcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sv/tcs_divsqrt.sv
// shared iterative unit: fixed point divide (one quotient bit a cycle)
// and integer square root (one root bit a cycle); depends on tcs_pkg
module tcs_divsqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tcs_pkg::tcs_req_t               req_i,
  input  logic signed [tcs_pkg::DW-1:0]   num_i,
  input  logic signed [tcs_pkg::DW-1:0]   den_i,
  input  logic [tcs_pkg::DW-2:0]          arg_i,
  output logic                            done_o,
  output logic signed [tcs_pkg::DW-1:0]   res_o
);
  import tcs_pkg::*;

  logic             busy_q;
  tcs_op_e          op_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] acc_q;
  logic [REM_W-1:0] rem_q;
  logic [ACC_W-1:0] quo_q;
  logic [DW-1:0]    den_q;
  logic             neg_q;
  logic             done_q;

  logic [DW-1:0]    num_mag;
  logic [REM_W-1:0] div_rem;
  logic [REM_W-1:0] sq_rem;
  logic [REM_W-1:0] sq_trial;

  assign num_mag  = num_i[DW-1] ? (~num_i + 1'b1) : num_i;
  assign div_rem  = {rem_q[REM_W-2:0], acc_q[ACC_W-1]};
  assign sq_rem   = {rem_q[REM_W-3:0], acc_q[ACC_W-1:ACC_W-2]};
  assign sq_trial = {quo_q[REM_W-3:0], 2'b01};

  // iteration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= (req_i.op == OP_DIV) ? CNT_W'(ACC_W) : CNT_W'(ACC_W / 2);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      rem_q <= '0;
      quo_q <= '0;
      neg_q <= num_i[DW-1];
      den_q <= (den_i < 1) ? DW'(1) : den_i;
      if (req_i.op == OP_DIV) begin
        acc_q <= ACC_W'(num_mag) << FRAC_BITS;
      end else begin
        acc_q <= ACC_W'(arg_i) << FRAC_BITS;
      end
    end else if (busy_q) begin
      if (op_q == OP_DIV) begin
        acc_q <= acc_q << 1;
        if (div_rem >= {1'b0, den_q}) begin
          rem_q <= div_rem - {1'b0, den_q};
          quo_q <= {quo_q[ACC_W-2:0], 1'b1};
        end else begin
          rem_q <= div_rem;
          quo_q <= {quo_q[ACC_W-2:0], 1'b0};
        end
      end else begin
        acc_q <= acc_q << 2;
        if (sq_rem >= sq_trial) begin
          rem_q <= sq_rem - sq_trial;
          quo_q <= {quo_q[ACC_W-2:0], 1'b1};
        end else begin
          rem_q <= sq_rem;
          quo_q <= {quo_q[ACC_W-2:0], 1'b0};
        end
      end
    end
  end

  // sign and saturation of the result
  always_comb begin
    if (op_q == OP_SQRT) begin
      res_o = (|quo_q[ACC_W-1:DW-1]) ? {1'b0, {(DW-1){1'b1}}} : quo_q[DW-1:0];
    end else if (neg_q) begin
      if ((|quo_q[ACC_W-1:DW]) || (quo_q[DW-1] && (|quo_q[DW-2:0]))) begin
        res_o = {1'b1, {(DW-1){1'b0}}};
      end else begin
        res_o = ~quo_q[DW-1:0] + 1'b1;
      end
    end else begin
      res_o = (|quo_q[ACC_W-1:DW-1]) ? {1'b0, {(DW-1){1'b1}}} : quo_q[DW-1:0];
    end
  end

  assign done_o = done_q;

endmodule

FILE: sv/tridiagonal_cholesky_sampler.sv
// top level of the tridiagonal cholesky sampler: sequencer, multiplier and stores
// depends on tcs_pkg, tcs_ram, tcs_divsqrt
//
// channel | signals                                      | moves
// cfg     | cfg_valid_i cfg_ready_o cfg_data_i           | off-diagonal register word
// in      | in_valid_i in_ready_o + four input fields    | one vector element word
// out     | out_valid_o out_ready_i + three result fields| one solution element word
//
// an element after the first takes two fixed point divides and one root in the shared
// divide / root unit, plus a multiply and add step for each;
// the first element skips the factor divide, a non-positive pivot the root.
// the back pass takes one divide an element; the output pass holds each word until taken.
// reset clears the sequencer, element count and error flag; the stores need no clear.
// input is taken only while the sequencer is idle; config writes are always taken.
module tridiagonal_cholesky_sampler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic signed [tcs_pkg::DW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcs_pkg::DW-2:0]        diag_value_i,
  input  logic signed [tcs_pkg::DW-1:0] location_value_i,
  input  logic signed [tcs_pkg::DW-1:0] noise_value_i,
  input  logic                          is_last_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [tcs_pkg::DW-1:0] solution_value_o,
  output logic                          is_last_out_o,
  output logic                          pivot_error_o
);
  import tcs_pkg::*;

  tcs_state_e state_q, state_d;

  logic signed [DW-1:0]     off_q;
  logic [CW-1:0]            count_q;
  logic                     err_q;
  logic [AW-1:0]            k_q;
  logic                     top_q;
  logic [DW-2:0]            diag_q;
  logic signed [DW-1:0]     loc_q;
  logic signed [DW-1:0]     noise_q;
  logic                     last_in_q;
  logic signed [DW-1:0]     l_q;
  logic signed [DW-1:0]     d_q;
  logic signed [DW-1:0]     dprev_q;
  logic signed [DW-1:0]     fwd_q;
  logic signed [DW-1:0]     x_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [MQ_W-1:0]   t_q;
  logic                     out_valid_q;
  logic signed [DW-1:0]     sol_q;
  logic                     last_out_q;

  logic                     in_fire;
  logic                     full;
  logic [AW-1:0]            j_idx;
  logic                     k_last;
  logic signed [SUM_W-1:0]  arg_sum;
  logic                     arg_pos;
  logic [DW-2:0]            arg_clamp;
  logic signed [DW-1:0]     mul_a;
  logic signed [DW-1:0]     mul_b;
  logic signed [DW-1:0]     fwd_num;
  logic signed [DW-1:0]     back_num;
  logic signed [DW-1:0]     work_new;

  tcs_req_t                 req;
  logic signed [DW-1:0]     u_num;
  logic signed [DW-1:0]     u_den;
  logic                     u_done;
  logic signed [DW-1:0]     u_res;

  logic                     piv_we, fac_we, work_we;
  logic [AW-1:0]            fac_waddr, work_waddr;
  logic [DW-1:0]            work_wdata;
  logic [DW-1:0]            piv_rd, fac_rd, work_rd;

  assign in_fire     = in_valid_i && in_ready_o;
  assign full        = (count_q == CW'(MAX_LEN));
  assign j_idx       = count_q[AW-1:0];
  assign k_last      = (CW'(k_q) == count_q - 1'b1);
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // pivot argument a_j - l^2, clamped into the root's range
  assign arg_sum   = $signed({{(SUM_W-DW+1){1'b0}}, diag_q}) - SUM_W'(t_q);
  assign arg_pos   = (arg_sum > 0);
  assign arg_clamp = (|arg_sum[SUM_W-1:DW-1]) ? {(DW-1){1'b1}} : arg_sum[DW-2:0];

  assign fwd_num  = sat32(SUM_W'(loc_q) - SUM_W'(t_q));
  assign back_num = sat32(SUM_W'($signed(work_rd)) - SUM_W'(t_q));
  assign work_new = sat32(SUM_W'(u_res) + SUM_W'(noise_q));

  // multiplier operand select
  always_comb begin
    unique case (state_q)
      S_MULA: begin
        mul_a = l_q;
        mul_b = l_q;
      end
      S_MULB: begin
        mul_a = l_q;
        mul_b = fwd_q;
      end
      default: begin
        mul_a = top_q ? '0 : $signed(fac_rd);
        mul_b = top_q ? '0 : x_q;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (full) begin
            state_d = is_last_in_i ? S_BINIT : S_IDLE;
          end else if (count_q == '0) begin
            state_d = S_MULA;
          end else begin
            state_d = S_LDIV;
          end
        end
      end
      S_LDIV:   state_d = S_LWAIT;
      S_LWAIT:  if (u_done) state_d = S_MULA;
      S_MULA:   state_d = S_TRNA;
      S_TRNA:   state_d = S_ARG;
      S_ARG:    state_d = arg_pos ? S_SQWAIT : S_MULB;
      S_SQWAIT: if (u_done) state_d = S_MULB;
      S_MULB:   state_d = S_TRNB;
      S_TRNB:   state_d = S_NUM;
      S_NUM:    state_d = S_WWAIT;
      S_WWAIT: begin
        if (u_done) begin
          state_d = last_in_q ? S_BINIT : S_IDLE;
        end
      end
      S_BINIT:  state_d = S_BRD;
      S_BRD:    state_d = S_BMUL;
      S_BMUL:   state_d = S_BTRN;
      S_BTRN:   state_d = S_BSUB;
      S_BSUB:   state_d = S_BWAIT;
      S_BWAIT: begin
        if (u_done) begin
          state_d = (k_q == '0) ? S_ORD : S_BRD;
        end
      end
      S_ORD:    state_d = S_OWAIT;
      S_OWAIT:  state_d = S_OHOLD;
      S_OHOLD: begin
        if (out_ready_i) begin
          state_d = k_last ? S_IDLE : S_ORD;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // unit requests and store writes
  always_comb begin
    req.start  = 1'b0;
    req.op     = OP_DIV;
    u_num      = off_q;
    u_den      = dprev_q;
    piv_we     = 1'b0;
    fac_we     = 1'b0;
    work_we    = 1'b0;
    fac_waddr  = j_idx - 1'b1;
    work_waddr = j_idx;
    work_wdata = work_new;
    unique case (state_q)
      S_LDIV: begin
        req.start = 1'b1;
      end
      S_LWAIT: begin
        fac_we = u_done;
      end
      S_ARG: begin
        req.start = arg_pos;
        req.op    = OP_SQRT;
      end
      S_NUM: begin
        req.start = 1'b1;
        u_num     = fwd_num;
        u_den     = d_q;
      end
      S_WWAIT: begin
        piv_we  = u_done;
        work_we = u_done;
      end
      S_BSUB: begin
        req.start = 1'b1;
        u_num     = back_num;
        u_den     = $signed(piv_rd);
      end
      S_BWAIT: begin
        work_we    = u_done;
        work_waddr = k_q;
        work_wdata = u_res;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      off_q       <= '0;
      count_q     <= '0;
      err_q       <= 1'b0;
      fwd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        off_q <= cfg_data_i;
      end
      if (state_q == S_ARG && !arg_pos) begin
        err_q <= 1'b1;
      end
      if (state_q == S_WWAIT && u_done) begin
        count_q <= count_q + 1'b1;
        fwd_q   <= u_res;
      end
      if (state_q == S_OWAIT) begin
        out_valid_q <= 1'b1;
      end
      if (state_q == S_OHOLD && out_ready_i) begin
        out_valid_q <= 1'b0;
        if (k_last) begin
          count_q <= '0;
          err_q   <= 1'b0;
          fwd_q   <= '0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      diag_q    <= diag_value_i;
      loc_q     <= location_value_i;
      noise_q   <= noise_value_i;
      last_in_q <= is_last_in_i;
      l_q       <= '0;
    end
    if (state_q == S_LWAIT && u_done) begin
      l_q <= u_res;
    end
    if (state_q == S_MULA || state_q == S_MULB || state_q == S_BMUL) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (state_q == S_TRNA || state_q == S_TRNB || state_q == S_BTRN) begin
      t_q <= trunc_q(prod_q);
    end
    if (state_q == S_ARG && !arg_pos) begin
      d_q <= DW'(1);
    end
    if (state_q == S_SQWAIT && u_done) begin
      d_q <= u_res;
    end
    if (state_q == S_WWAIT && u_done) begin
      dprev_q <= d_q;
    end
    if (state_q == S_BINIT) begin
      k_q   <= AW'(count_q - 1'b1);
      top_q <= 1'b1;
    end
    if (state_q == S_BWAIT && u_done) begin
      x_q   <= u_res;
      top_q <= 1'b0;
      if (k_q != '0) begin
        k_q <= k_q - 1'b1;
      end
    end
    if (state_q == S_OWAIT) begin
      sol_q      <= $signed(work_rd);
      last_out_q <= k_last;
    end
    if (state_q == S_OHOLD && out_ready_i && !k_last) begin
      k_q <= k_q + 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign solution_value_o = sol_q;
  assign is_last_out_o    = last_out_q;
  assign pivot_error_o    = err_q;

  // shared divide / root unit
  tcs_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .num_i  (u_num),
    .den_i  (u_den),
    .arg_i  (arg_clamp),
    .done_o (u_done),
    .res_o  (u_res)
  );

  // pivot store d_j
  tcs_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_piv_ram (
    .clk_i   (clk_i),
    .we_i    (piv_we),
    .waddr_i (j_idx),
    .wdata_i (d_q),
    .raddr_i (k_q),
    .rdata_o (piv_rd)
  );

  // factor off-diagonal store l_j
  tcs_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_fac_ram (
    .clk_i   (clk_i),
    .we_i    (fac_we),
    .waddr_i (fac_waddr),
    .wdata_i (u_res),
    .raddr_i (k_q),
    .rdata_o (fac_rd)
  );

  // work store, forward values then solution
  tcs_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (work_we),
    .waddr_i (work_waddr),
    .wdata_i (work_wdata),
    .raddr_i (k_q),
    .rdata_o (work_rd)
  );

endmodule

FILE: bench/testbench.sv
// self-checking bench for tridiagonal_cholesky_sampler: random and directed vectors
// depends on tcs_pkg and the sampler rtl; predicts every solution word in place
`timescale 1ns / 100ps

module testbench;
  import tcs_pkg::*;

  typedef struct {
    logic [DW-2:0]        diag;
    logic signed [DW-1:0] loc;
    logic signed [DW-1:0] noise;
    logic                 last;
  } elem_t;

  typedef struct {
    logic signed [DW-1:0] value;
    logic                 last;
    logic                 err;
  } sol_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic signed [DW-1:0] cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [DW-2:0]        diag_value_i;
  logic signed [DW-1:0] location_value_i;
  logic signed [DW-1:0] noise_value_i;
  logic                 is_last_in_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic signed [DW-1:0] solution_value_o;
  logic                 is_last_out_o;
  logic                 pivot_error_o;

  tridiagonal_cholesky_sampler dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .diag_value_i(diag_value_i), .location_value_i(location_value_i),
    .noise_value_i(noise_value_i), .is_last_in_i(is_last_in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .solution_value_o(solution_value_o), .is_last_out_o(is_last_out_o),
    .pivot_error_o(pivot_error_o)
  );

  elem_t pending_elems[$];
  sol_t  expected_sols[$];
  int    error_count = 0;
  int    elems_taken = 0;
  int    sols_seen   = 0;
  int    vectors_sent = 0;

  // solver model state
  logic signed [DW-1:0] off_diag = 0;
  logic signed [DW-1:0] pivots[MAX_LEN];
  logic signed [DW-1:0] factors[MAX_LEN];
  logic signed [DW-1:0] work_vals[MAX_LEN];
  int                   held = 0;
  logic                 pivot_bad = 1'b0;
  logic signed [DW-1:0] fwd_last = 0;

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic signed [DW-1:0] clamp_word(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[DW-1:0];
  endfunction

  function automatic longint fix_mul(logic signed [DW-1:0] a, logic signed [DW-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p / (longint'(1) << FRAC_BITS);
  endfunction

  function automatic logic signed [DW-1:0] fix_div(logic signed [DW-1:0] num,
                                                    logic signed [DW-1:0] den);
    longint n;
    longint d;
    n = longint'(num) * (longint'(1) << FRAC_BITS);
    d = (den < 1) ? 1 : longint'(den);
    return clamp_word(n / d);
  endfunction

  function automatic longint unsigned int_root(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [DW-1:0] pivot_of(longint arg);
    longint unsigned r;
    if (arg <= 0) begin
      pivot_bad = 1'b1;
      return 1;
    end
    if (arg > 64'sd2147483647) arg = 64'sd2147483647;
    r = int_root(longint'(arg) << FRAC_BITS);
    if (r < 1) r = 1;
    if (r > 64'd2147483647) r = 64'd2147483647;
    return r[DW-1:0];
  endfunction

  // extend the factorization by one element; solve and queue words on the last mark
  task automatic solve_element(elem_t e);
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] w;
    logic signed [DW-1:0] num;
    logic signed [DW-1:0] l;
    sol_t s;
    int j;
    if (held < MAX_LEN) begin
      j = held;
      if (j == 0) begin
        d   = pivot_of(longint'({1'b0, e.diag}));
        num = e.loc;
      end else begin
        l = fix_div(off_diag, pivots[j-1]);
        factors[j-1] = l;
        d   = pivot_of(longint'({1'b0, e.diag}) - fix_mul(l, l));
        num = clamp_word(longint'(e.loc) - fix_mul(l, fwd_last));
      end
      pivots[j] = d;
      w = fix_div(num, d);
      fwd_last = w;
      work_vals[j] = clamp_word(longint'(w) + longint'(e.noise));
      held = j + 1;
    end
    if (e.last) begin
      work_vals[held-1] = fix_div(work_vals[held-1], pivots[held-1]);
      for (int k = held - 1; k > 0; k--) begin
        work_vals[k-1] = fix_div(clamp_word(longint'(work_vals[k-1]) -
                                            fix_mul(factors[k-1], work_vals[k])),
                                 pivots[k-1]);
      end
      for (int k = 0; k < held; k++) begin
        s.value = work_vals[k];
        s.last  = (k + 1 == held);
        s.err   = pivot_bad;
        expected_sols.push_back(s);
      end
      held      = 0;
      pivot_bad = 1'b0;
      fwd_last  = 0;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s at word %0d: got %0d, expected %0d",
             $time, what, sols_seen, got, want);
    error_count++;
  endtask

  // idle rates by stage of the run
  function automatic int sender_idle();
    if (elems_taken < 90) return 26;
    if (elems_taken < 170) return 56;
    return 0;
  endfunction

  function automatic int receiver_idle();
    if (elems_taken < 90) return 56;
    if (elems_taken < 170) return 26;
    return 0;
  endfunction

  // element driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      diag_value_i     <= '0;
      location_value_i <= '0;
      noise_value_i    <= '0;
      is_last_in_i     <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_elems.size() > 0 && $urandom_range(99) >= sender_idle()) begin
        elem_t e;
        e = pending_elems.pop_front();
        in_valid_i       <= 1'b1;
        diag_value_i     <= e.diag;
        location_value_i <= e.loc;
        noise_value_i    <= e.noise;
        is_last_in_i     <= e.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // accepted words: predict on input, check on output
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_idle());
      if (in_valid_i && in_ready_o) begin
        elem_t e;
        e.diag  = diag_value_i;
        e.loc   = location_value_i;
        e.noise = noise_value_i;
        e.last  = is_last_in_i;
        solve_element(e);
        elems_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_sols.size() == 0) begin
          report_mismatch("unexpected solution_value", solution_value_o, 0);
        end else begin
          sol_t s;
          s = expected_sols.pop_front();
          if (solution_value_o !== s.value)
            report_mismatch("solution_value", solution_value_o, s.value);
          if (is_last_out_o !== s.last)
            report_mismatch("is_last_out", is_last_out_o, s.last);
          if (pivot_error_o !== s.err)
            report_mismatch("pivot_error", pivot_error_o, s.err);
        end
        sols_seen++;
      end
    end
  end

  task automatic add_elem(logic [DW-2:0] d, logic signed [DW-1:0] loc,
                          logic signed [DW-1:0] nz, logic last);
    elem_t e;
    e.diag = d; e.loc = loc; e.noise = nz; e.last = last;
    pending_elems.push_back(e);
  endtask

  // random vector: mostly well-conditioned diagonals, some wild ones
  task automatic add_vector(int len);
    logic [DW-1:0] r;
    logic [DW-2:0] d;
    logic signed [DW-1:0] loc;
    logic signed [DW-1:0] nz;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: r = $urandom();
        1: r = $urandom_range(0, 1 << 18);
        default: r = $urandom_range(1 << 20, 16 << 20);
      endcase
      d = r[DW-2:0];
      loc = ($urandom_range(3) == 0) ? $signed($urandom())
                                     : $signed($urandom_range(0, 8 << 20)) - (4 << 20);
      nz  = ($urandom_range(4) == 0) ? $signed($urandom())
                                     : $signed($urandom_range(0, 4 << 20)) - (2 << 20);
      add_elem(d, loc, nz, i == len - 1);
    end
    vectors_sent++;
  endtask

  // hold the sender until the block is drained and settled
  task automatic drain();
    while (pending_elems.size() != 0 || in_valid_i || expected_sols.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_off_diag(logic signed [DW-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    off_diag = v;
    cfg_valid_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    wait (rst_ni === 1'b1);
    repeat (3) @(posedge clk_i);

    // directed: zero pivot, single elements, field extremes
    add_elem('0, 32'sh7fffffff, 32'sh80000000, 1'b1);
    add_elem('1, 32'sh80000000, 32'sh7fffffff, 1'b1);
    add_elem(31'd1 << 20, 32'sd1 << 20, 0, 1'b0);
    add_elem('1, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    add_elem('0, 32'sh80000000, 32'sh80000000, 1'b1);
    vectors_sent += 3;
    drain();
    write_off_diag(32'sh7fffffff);
    add_elem(31'd4 << 20, 32'sd1 << 20, 0, 1'b0);
    add_elem(31'd1 << 20, -(32'sd1 << 20), 32'sd5, 1'b0);
    add_elem('1, 32'sd0, 32'sd0, 1'b1);
    vectors_sent++;
    drain();
    write_off_diag(32'sh80000000);
    add_elem(31'd1, 32'sd3, -32'sd3, 1'b0);
    add_elem('1, 32'sh7fffffff, 32'sh80000000, 1'b0);
    add_elem(31'd2 << 20, 32'sd100, 32'sd0, 1'b1);
    vectors_sent++;
    drain();
    write_off_diag(-(32'sd1 << 19));
    add_vector(4);
    drain();

    // random vectors under a few couplings; one full and one overflowing vector
    write_off_diag($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    repeat (8) add_vector($urandom_range(1, 8));
    add_vector(64);
    drain();
    write_off_diag($signed($urandom()));
    repeat (10) add_vector($urandom_range(1, 6));
    drain();
    write_off_diag($signed($urandom_range(0, 3 << 20)) - (3 << 19));
    add_vector(66);
    repeat (5) add_vector($urandom_range(1, 8));
    drain();
    write_off_diag(32'sd0);
    repeat (6) add_vector($urandom_range(1, 5));
    drain();

    $display("ran %0d vectors, %0d elements, %0d solution words checked",
             vectors_sent, elems_taken, sols_seen);
    $display("covered zero pivots, full and overflowing buffers, extreme couplings");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout with %0d solution words outstanding", expected_sols.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
